@@ src/sai_pkg.sv @@
// Package for suffix array interval refinement: types, codes and default depths.
package sai_pkg;

  localparam int DEF_REF_DEPTH = 65536;
  localparam int DEF_SA_DEPTH  = 65536;

  localparam int CHAR_W = 8;
  localparam int POS_W  = 16;
  localparam int LEN_W  = 17;
  localparam int BND_W  = 18;

  typedef enum logic [1:0] {
    MODE_LOAD_REF = 2'd0,
    MODE_LOAD_SA  = 2'd1,
    MODE_QUERY    = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SA,
    ST_REF
  } state_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_LAST,
    PH_LEFT,
    PH_RIGHT
  } phase_t;

endpackage

@@ src/suffix_array_interval_narrow.sv @@
// Top level: suffix array interval refinement by one character over two RAMs.
//
//  channel  handshake          payload
//  input    start / busy       in_mode, in_load_address, in_load_value, in_query_char,
//                              in_match_depth, in_interval_start, in_interval_end
//  result   out_valid strobe   out_new_start, out_new_end, out_found
//  config   cfg_we             cfg_wdata (reference_length)
//
// Load words never raise busy. A query does each character fetch as a suffix
// array read, then a reference read: one fetch each for the first and last
// suffix, then one per binary search step, at most 16 steps per search. The
// next word can be taken in the result cycle. Reset clears control and the
// length register; RAM contents are undefined until loaded. Results are a
// one-cycle strobe, no stall.
module suffix_array_interval_narrow
  import sai_pkg::*;
#(
  parameter int REF_DEPTH = DEF_REF_DEPTH,
  parameter int SA_DEPTH  = DEF_SA_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_mode,
  input  logic [POS_W-1:0]  in_load_address,
  input  logic [POS_W-1:0]  in_load_value,
  input  logic [CHAR_W-1:0] in_query_char,
  input  logic [POS_W-1:0]  in_match_depth,
  input  logic [POS_W-1:0]  in_interval_start,
  input  logic [POS_W-1:0]  in_interval_end,
  output logic              out_valid,
  output logic [LEN_W-1:0]  out_new_start,
  output logic [POS_W-1:0]  out_new_end,
  output logic              out_found,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata
);

  localparam int REF_AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int SA_AW  = (SA_DEPTH > 1) ? $clog2(SA_DEPTH) : 1;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0] ref_len_r;

  logic [CHAR_W-1:0] char_r, char_nxt;
  logic [POS_W-1:0]  depth_r, depth_nxt;
  logic [POS_W-1:0]  s_r, s_nxt, e_r, e_nxt;
  logic [POS_W-1:0]  mid_r, mid_nxt;
  logic signed [BND_W-1:0] l_r, l_nxt, r_r, r_nxt, l2_r, l2_nxt, r2_r, r2_nxt;
  logic hit_r, hit_nxt;
  logic cf_neg_r, cf_neg_nxt, cf_zero_r, cf_zero_nxt, cl_zero_r, cl_zero_nxt;
  logic sa_ok_r, sa_ok_nxt, ref_ok_r, ref_ok_nxt;
  logic [LEN_W-1:0]  out_new_start_r, out_new_start_nxt;
  logic [POS_W-1:0]  out_new_end_r, out_new_end_nxt;
  logic              out_found_r, out_found_nxt;

  logic              accept;
  logic [POS_W-1:0]  rd_idx;
  logic [LEN_W-1:0]  ref_addr;
  logic [CHAR_W-1:0] ch;

  logic              ref_we, sa_we;
  logic [SA_AW-1:0]  sa_raddr;
  logic [POS_W-1:0]  sa_rdata;
  logic [REF_AW-1:0] ref_raddr;
  logic [CHAR_W-1:0] ref_rdata;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign ref_we = accept && (in_mode == MODE_LOAD_REF) && (32'(in_load_address) < REF_DEPTH);
  assign sa_we  = accept && (in_mode == MODE_LOAD_SA) && (32'(in_load_address) < SA_DEPTH);
  assign sa_raddr  = SA_AW'(rd_idx);
  assign ref_addr  = (sa_ok_r ? {1'b0, sa_rdata} : LEN_W'(0)) + {1'b0, depth_r};
  assign ref_raddr = REF_AW'(ref_addr);
  assign ch        = ref_ok_r ? ref_rdata : CHAR_W'(0);

  sai_ram #(.WIDTH(CHAR_W), .DEPTH(REF_DEPTH)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (REF_AW'(in_load_address)),
    .wdata (in_load_value[CHAR_W-1:0]),
    .raddr (ref_raddr),
    .rdata (ref_rdata)
  );

  sai_ram #(.WIDTH(POS_W), .DEPTH(SA_DEPTH)) u_sa_ram (
    .clk   (clk),
    .we    (sa_we),
    .waddr (SA_AW'(in_load_address)),
    .wdata (in_load_value),
    .raddr (sa_raddr),
    .rdata (sa_rdata)
  );

  always_comb begin
    logic signed [BND_W-1:0] lv, rv, l2v, r2v, mv, sum;
    logic hitv, chk_left, chk_right, fin, cl_zero_v;
    lv        = l_r;
    rv        = r_r;
    l2v       = l2_r;
    r2v       = r2_r;
    hitv      = hit_r;
    chk_left  = 1'b0;
    chk_right = 1'b0;
    fin       = 1'b0;
    cl_zero_v = cl_zero_r;
    mv        = $signed({2'b00, mid_r});
    sum       = '0;

    state_nxt   = state_r;
    phase_nxt   = phase_r;
    out_valid_nxt = 1'b0;
    char_nxt    = char_r;
    depth_nxt   = depth_r;
    s_nxt       = s_r;
    e_nxt       = e_r;
    mid_nxt     = mid_r;
    l_nxt       = l_r;
    r_nxt       = r_r;
    l2_nxt      = l2_r;
    r2_nxt      = r2_r;
    hit_nxt     = hit_r;
    cf_neg_nxt  = cf_neg_r;
    cf_zero_nxt = cf_zero_r;
    cl_zero_nxt = cl_zero_r;
    sa_ok_nxt   = sa_ok_r;
    ref_ok_nxt  = ref_ok_r;
    out_new_start_nxt = out_new_start_r;
    out_new_end_nxt   = out_new_end_r;
    out_found_nxt     = out_found_r;
    rd_idx      = in_interval_start;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_mode == MODE_QUERY)) begin
          char_nxt  = in_query_char;
          depth_nxt = in_match_depth;
          s_nxt     = in_interval_start;
          e_nxt     = in_interval_end;
          rd_idx    = in_interval_start;
          sa_ok_nxt = 32'(in_interval_start) < SA_DEPTH;
          phase_nxt = PH_FIRST;
          state_nxt = ST_SA;
        end
      end
      ST_SA: begin
        ref_ok_nxt = (ref_addr < ref_len_r) && (32'(ref_addr) < REF_DEPTH);
        state_nxt  = ST_REF;
      end
      ST_REF: begin
        unique case (phase_r)
          PH_FIRST: begin
            cf_neg_nxt  = char_r < ch;
            cf_zero_nxt = char_r == ch;
          end
          PH_LAST: begin
            cl_zero_v   = char_r == ch;
            cl_zero_nxt = cl_zero_v;
            if (cf_neg_r) begin
              lv  = $signed({2'b00, s_r}) + 18'sd1;
              l2v = $signed({2'b00, s_r});
              fin = 1'b1;
            end else if (char_r > ch) begin
              lv  = $signed({2'b00, e_r}) + 18'sd1;
              l2v = $signed({2'b00, e_r});
              fin = 1'b1;
            end else begin
              lv  = $signed({2'b00, s_r});
              rv  = $signed({2'b00, e_r});
              l2v = $signed({2'b00, s_r});
              r2v = $signed({2'b00, e_r});
              hitv = cf_zero_r;
              chk_left  = !cf_zero_r;
              chk_right = cf_zero_r;
            end
          end
          PH_LEFT: begin
            if (char_r <= ch) begin
              if (!hitv && (char_r == ch)) begin
                hitv = 1'b1;
                l2v  = mv;
                r2v  = rv;
              end
              rv = mv;
            end else begin
              lv = mv;
            end
            chk_left = 1'b1;
          end
          PH_RIGHT: begin
            if (char_r < ch) begin
              r2v = mv;
            end else begin
              l2v = mv;
            end
            chk_right = 1'b1;
          end
          default: ;
        endcase

        if (phase_r == PH_FIRST) begin
          rd_idx    = e_r;
          sa_ok_nxt = 32'(e_r) < SA_DEPTH;
          phase_nxt = PH_LAST;
          state_nxt = ST_SA;
        end

        if (chk_left) begin
          if (rv - lv > 18'sd1) begin
            sum       = lv + rv;
            mid_nxt   = sum[POS_W:1];
            rd_idx    = sum[POS_W:1];
            sa_ok_nxt = 32'(sum[POS_W:1]) < SA_DEPTH;
            phase_nxt = PH_LEFT;
            state_nxt = ST_SA;
          end else begin
            lv = rv;
            if (!hitv) begin
              l2v = lv - 18'sd1;
            end
            chk_right = 1'b1;
          end
        end

        if (chk_right) begin
          if (cl_zero_v) begin
            l2v = $signed({2'b00, e_r});
            fin = 1'b1;
          end else if (r2v - l2v > 18'sd1) begin
            sum       = l2v + r2v;
            mid_nxt   = sum[POS_W:1];
            rd_idx    = sum[POS_W:1];
            sa_ok_nxt = 32'(sum[POS_W:1]) < SA_DEPTH;
            phase_nxt = PH_RIGHT;
            state_nxt = ST_SA;
          end else begin
            fin = 1'b1;
          end
        end

        if (fin) begin
          out_valid_nxt     = 1'b1;
          out_new_start_nxt = lv[LEN_W-1:0];
          out_new_end_nxt   = l2v[POS_W-1:0];
          out_found_nxt     = lv <= l2v;
          state_nxt         = ST_IDLE;
        end

        l_nxt   = lv;
        r_nxt   = rv;
        l2_nxt  = l2v;
        r2_nxt  = r2v;
        hit_nxt = hitv;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_FIRST;
      out_valid_r <= 1'b0;
      ref_len_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        ref_len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    char_r    <= char_nxt;
    depth_r   <= depth_nxt;
    s_r       <= s_nxt;
    e_r       <= e_nxt;
    mid_r     <= mid_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    l2_r      <= l2_nxt;
    r2_r      <= r2_nxt;
    hit_r     <= hit_nxt;
    cf_neg_r  <= cf_neg_nxt;
    cf_zero_r <= cf_zero_nxt;
    cl_zero_r <= cl_zero_nxt;
    sa_ok_r   <= sa_ok_nxt;
    ref_ok_r  <= ref_ok_nxt;
    out_new_start_r <= out_new_start_nxt;
    out_new_end_r   <= out_new_end_nxt;
    out_found_r     <= out_found_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_new_start = out_new_start_r;
  assign out_new_end   = out_new_end_r;
  assign out_found     = out_found_r;

endmodule

@@ src/sai_ram.sv @@
// Generic simple dual-port RAM with registered read.
module sai_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/suffix_array_interval_narrow_tb.sv @@
// Testbench for suffix_array_interval_narrow: directed table, then sorted-text queries vs predictor.
`timescale 1ns / 1ps

module suffix_array_interval_narrow_tb;
  import sai_pkg::*;

  localparam int QUIET       = 80;
  localparam int LIMIT       = 1000000;
  localparam int MAX_N       = 48;
  localparam int PHASE_WORDS = 550;
  localparam int CHAIN_DEPTH = 12;

  typedef struct packed {
    logic [LEN_W-1:0] new_start;
    logic [POS_W-1:0] new_end;
    logic             found;
  } border_t;

  typedef struct packed {
    mode_t             mode;
    logic [POS_W-1:0]  addr;
    logic [POS_W-1:0]  val;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  depth;
    logic [POS_W-1:0]  s;
    logic [POS_W-1:0]  e;
  } cmd_t;

  typedef struct {
    bit          is_cfg;
    cmd_t        w;
    int unsigned len;
    bit          typed;
    border_t     want;
  } step_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_mode;
  logic [POS_W-1:0]  in_load_address;
  logic [POS_W-1:0]  in_load_value;
  logic [CHAR_W-1:0] in_query_char;
  logic [POS_W-1:0]  in_match_depth;
  logic [POS_W-1:0]  in_interval_start;
  logic [POS_W-1:0]  in_interval_end;
  logic              out_valid;
  logic [LEN_W-1:0]  out_new_start;
  logic [POS_W-1:0]  out_new_end;
  logic              out_found;
  logic              cfg_we;
  logic [LEN_W-1:0]  cfg_wdata;

  bit [CHAR_W-1:0] ref_mirror [0:DEF_REF_DEPTH-1];
  bit [POS_W-1:0]  sa_mirror [0:DEF_SA_DEPTH-1];
  int              ref_len;

  border_t   narrowed_q [$];
  step_row_t plan [$];
  bit [7:0]  txt [0:MAX_N-1];
  int        sfx [0:MAX_N-1];
  int        idle_plan [3] = '{0, 78, 9};
  int        idle_pct;
  int        words_sent;
  int        mismatches;
  int        cycles;

  suffix_array_interval_narrow DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_load_address   (in_load_address),
    .in_load_value     (in_load_value),
    .in_query_char     (in_query_char),
    .in_match_depth    (in_match_depth),
    .in_interval_start (in_interval_start),
    .in_interval_end   (in_interval_end),
    .out_valid         (out_valid),
    .out_new_start     (out_new_start),
    .out_new_end       (out_new_end),
    .out_found         (out_found),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int char_at_depth(int idx, bit [15:0] depth);
    int addr;
    if (idx < 0 || idx >= DEF_SA_DEPTH) begin
      addr = int'(depth);
    end else begin
      addr = int'(sa_mirror[idx]) + int'(depth);
    end
    if (addr >= ref_len || addr >= DEF_REF_DEPTH) return 0;
    return int'(ref_mirror[addr]);
  endfunction

  function automatic border_t narrow_interval(bit [7:0] ch, bit [15:0] depth,
                                              bit [15:0] s_in, bit [15:0] e_in);
    int c, s, e, l, r, m, l2, r2, d, cf, cl;
    bit hit;
    border_t res;
    c = ch;
    s = s_in;
    e = e_in;
    l = s;
    r = e;
    l2 = s;
    r2 = e;
    hit = 1'b0;
    cf = c - char_at_depth(s, depth);
    cl = c - char_at_depth(e, depth);
    if (cf < 0) begin
      l = s + 1;
      l2 = s;
    end else if (cl > 0) begin
      l = e + 1;
      l2 = e;
    end else begin
      if (cf == 0) begin
        hit = 1'b1;
        r2 = r;
      end else begin
        // left border: first suffix whose char is not below c
        while (r - l > 1) begin
          m = (l + r) / 2;
          d = c - char_at_depth(m, depth);
          if (d <= 0) begin
            if (!hit && d == 0) begin
              hit = 1'b1;
              l2 = m;
              r2 = r;
            end
            r = m;
          end else begin
            l = m;
          end
        end
        l = r;
      end
      if (!hit) l2 = l - 1;
      if (cl == 0) begin
        l2 = e;
      end else begin
        while (r2 - l2 > 1) begin
          m = (l2 + r2) / 2;
          d = c - char_at_depth(m, depth);
          if (d < 0) r2 = m;
          else l2 = m;
        end
      end
    end
    res.new_start = l[LEN_W-1:0];
    res.new_end   = l2[POS_W-1:0];
    res.found     = (l <= l2);
    return res;
  endfunction

  function automatic bit suffix_before(int a, int b, int n);
    int k;
    for (k = 0; a + k < n && b + k < n; k++) begin
      if (txt[a+k] != txt[b+k]) return txt[a+k] < txt[b+k];
    end
    return a + k >= n;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t w;
    w.mode  = MODE_NONE;
    w.addr  = 16'($urandom);
    w.val   = 16'($urandom);
    w.ch    = 8'($urandom);
    w.depth = 16'($urandom);
    w.s     = 16'($urandom);
    w.e     = 16'($urandom);
    return w;
  endfunction

  function automatic void add_step(bit is_cfg, mode_t m, int a, int v, int c, int dp,
                                   int s, int e, int len, bit typed, int xs, int xe, bit xf);
    step_row_t row;
    row.is_cfg         = is_cfg;
    row.w.mode         = m;
    row.w.addr         = a[POS_W-1:0];
    row.w.val          = v[POS_W-1:0];
    row.w.ch           = c[CHAR_W-1:0];
    row.w.depth        = dp[POS_W-1:0];
    row.w.s            = s[POS_W-1:0];
    row.w.e            = e[POS_W-1:0];
    row.len            = len;
    row.typed          = typed;
    row.want.new_start = xs[LEN_W-1:0];
    row.want.new_end   = xe[POS_W-1:0];
    row.want.found     = xf;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) log_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endfunction

  task automatic send_word(cmd_t w, bit typed, border_t want);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start             <= 1'b1;
    in_mode           <= w.mode;
    in_load_address   <= w.addr;
    in_load_value     <= w.val;
    in_query_char     <= w.ch;
    in_match_depth    <= w.depth;
    in_interval_start <= w.s;
    in_interval_end   <= w.e;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (w.mode)
      MODE_LOAD_REF: ref_mirror[w.addr] = w.val[CHAR_W-1:0];
      MODE_LOAD_SA:  sa_mirror[w.addr] = w.val;
      MODE_QUERY:    narrowed_q.insert(narrowed_q.size(), typed ? want
                                       : narrow_interval(w.ch, w.depth, w.s, w.e));
      default: ;
    endcase
    if (w.mode != MODE_NONE) words_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (narrowed_q.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic write_length(int unsigned v);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[LEN_W-1:0];
    ref_len = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_data_set();
    int n, width, base, len, p, d, s, e, done, i, j, key;
    border_t nx;
    cmd_t w;
    n = $urandom_range(1, MAX_N);
    width = $urandom_range(1, 4);
    base = ($urandom_range(3) == 0) ? $urandom_range(0, 256 - width) : 8'h61;
    for (i = 0; i < n; i++) txt[i] = 8'(base + $urandom_range(0, width - 1));
    for (i = 0; i < n; i++) sfx[i] = i;
    for (i = 1; i < n; i++) begin
      key = sfx[i];
      j = i - 1;
      while (j >= 0 && suffix_before(key, sfx[j], n)) begin
        sfx[j+1] = sfx[j];
        j--;
      end
      sfx[j+1] = key;
    end
    for (i = 0; i < n; i++) begin
      w = random_cmd();
      w.mode = MODE_LOAD_REF;
      w.addr = 16'(i);
      w.val[CHAR_W-1:0] = txt[i];
      send_word(w, 1'b0, '0);
      w = random_cmd();
      w.mode = MODE_LOAD_SA;
      w.addr = 16'(i);
      w.val = 16'(sfx[i]);
      send_word(w, 1'b0, '0);
    end
    case ($urandom_range(7))
      0: len = 0;
      1: len = $urandom_range(0, n);
      default: len = n;
    endcase
    write_length(len);
    done = 0;
    while (done < 40) begin
      w = random_cmd();
      case ($urandom_range(9))
        0: begin
          // noise: ignored mode, a load that breaks the sort order, or a far load
          case ($urandom_range(2))
            0: w.mode = MODE_NONE;
            1: begin
              w.mode = MODE_LOAD_SA;
              w.addr = 16'($urandom_range(0, n - 1));
            end
            default: begin
              if ($urandom_range(1) == 0) w.mode = MODE_LOAD_REF;
              else w.mode = MODE_LOAD_SA;
              w.addr = 16'($urandom_range(MAX_N, 65535));
            end
          endcase
          send_word(w, 1'b0, '0);
          done++;
        end
        1: begin
          w.mode = MODE_QUERY;
          w.s = 16'($urandom_range(0, n - 1));
          w.e = 16'($urandom_range(0, n - 1));
          if ($urandom_range(1) == 0) w.ch = txt[$urandom_range(0, n - 1)];
          if ($urandom_range(3) != 0) w.depth = 16'($urandom_range(0, n + 1));
          send_word(w, 1'b0, '0);
          done++;
        end
        default: begin
          // walk a pattern taken from the text down the suffix array
          s = 0;
          e = n - 1;
          d = 0;
          p = $urandom_range(0, n - 1);
          forever begin
            w = random_cmd();
            w.mode  = MODE_QUERY;
            w.s     = 16'(s);
            w.e     = 16'(e);
            w.depth = 16'(d);
            if (p + d < n && $urandom_range(7) != 0) w.ch = txt[p+d];
            nx = narrow_interval(w.ch, w.depth, w.s, w.e);
            send_word(w, 1'b0, '0);
            done++;
            if (!nx.found || d >= CHAIN_DEPTH) break;
            s = nx.new_start;
            e = nx.new_end;
            d++;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin : result_check
    border_t want;
    if (rst_n && out_valid) begin
      if (narrowed_q.size() == 0) begin
        log_mismatch($sformatf("unexpected word start=%0d end=%0d found=%0d",
                               out_new_start, out_new_end, out_found));
      end else begin
        want = narrowed_q.pop_front();
        check_field("new_start", want.new_start, out_new_start);
        check_field("new_end", want.new_end, out_new_end);
        check_field("found", want.found, out_found);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("suffix_array_interval_narrow_tb failed");
      $finish;
    end
  end

  initial begin
    int i, ph, first;
    cycles = 0;
    mismatches = 0;
    words_sent = 0;
    idle_pct = 0;
    ref_len = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_NONE;
    in_load_address = '0;
    in_load_value = '0;
    in_query_char = '0;
    in_match_depth = '0;
    in_interval_start = '0;
    in_interval_end = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;

    add_step(0, MODE_LOAD_SA, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(0, MODE_LOAD_SA, 65535, 65535, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(0, MODE_LOAD_REF, 0, 'hFF41, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(0, MODE_LOAD_REF, 65535, 'h00FF, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(0, MODE_NONE, 0, 'h5A5A, 255, 65535, 65535, 65535, 0, 0, 0, 0, 0);
    // length still zero after reset: every char reads as zero
    add_step(0, MODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1);
    add_step(1, MODE_NONE, 0, 0, 0, 0, 0, 0, 65536, 0, 0, 0, 0);
    // below first suffix
    add_step(0, MODE_QUERY, 0, 0, 0, 0, 0, 65535, 0, 1, 1, 0, 0);
    // above last suffix, new_start reaches 65536
    add_step(0, MODE_QUERY, 0, 0, 255, 65535, 0, 65535, 0, 1, 65536, 65535, 0);
    add_step(0, MODE_QUERY, 0, 0, 255, 0, 65535, 65535, 0, 1, 65535, 65535, 1);
    // inverted interval, right border wraps
    add_step(0, MODE_QUERY, 0, 0, 'h80, 65535, 65535, 0, 0, 1, 0, 65535, 0);
    add_step(0, MODE_QUERY, 0, 0, 0, 65535, 65535, 0, 0, 0, 0, 0, 0);
    // text ACAB, suffix array 2 0 3 1
    add_step(0, MODE_LOAD_REF, 1, 'h43, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(0, MODE_LOAD_REF, 2, 'h41, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(0, MODE_LOAD_REF, 3, 'h42, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(0, MODE_LOAD_SA, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(0, MODE_LOAD_SA, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(0, MODE_LOAD_SA, 2, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(0, MODE_LOAD_SA, 3, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(1, MODE_NONE, 0, 0, 0, 0, 0, 0, 4, 0, 0, 0, 0);
    add_step(0, MODE_QUERY, 0, 0, 'h41, 0, 0, 3, 0, 0, 0, 0, 0);
    add_step(0, MODE_QUERY, 0, 0, 'h42, 1, 0, 1, 0, 0, 0, 0, 0);
    add_step(0, MODE_QUERY, 0, 0, 'h42, 0, 0, 3, 0, 0, 0, 0, 0);
    add_step(0, MODE_QUERY, 0, 0, 'h44, 3, 0, 3, 0, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) write_length(plan[i].len);
      else send_word(plan[i].w, plan[i].typed, plan[i].want);
    end

    for (ph = 0; ph < 3; ph++) begin
      idle_pct = idle_plan[ph];
      first = words_sent;
      while (words_sent - first < PHASE_WORDS) run_data_set();
    end

    settle();
    if (mismatches == 0 && narrowed_q.size() == 0) begin
      $display("suffix_array_interval_narrow_tb passed");
    end else begin
      $display("suffix_array_interval_narrow_tb failed");
    end
    $finish;
  end

endmodule

@@ suffix_array_interval_narrow.f @@
src/sai_pkg.sv
src/sai_ram.sv
src/suffix_array_interval_narrow.sv
tb/suffix_array_interval_narrow_tb.sv
